### hw/rtl/sfs_pkg.sv
// shared types and constants for the sprite frame sequencer
`default_nettype none

package sfs_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int TICK_W     = 17;
  localparam int IVAL_W     = 16;
  localparam int LOOP_W     = 8;
  localparam int LIMIT_W    = 9;
  localparam int POS_W      = 10;
  localparam int COLS_W     = 7;
  localparam int CELL_W     = 10;
  localparam int SUM_W      = 11;
  localparam int TX_W       = 16;
  localparam int TY_W       = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RESTART = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NOP     = 2'd3
  } sfs_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT   = 3'd0,
    REG_LOOP_LIMIT    = 3'd1,
    REG_START_POS     = 3'd2,
    REG_SHEET_COLUMNS = 3'd3,
    REG_CELL_WIDTH    = 3'd4,
    REG_CELL_HEIGHT   = 3'd5,
    REG_BASE_INTERVAL = 3'd6
  } sfs_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_FINISH
  } sfs_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [FRAME_W-1:0] entry_index;
    logic [IVAL_W-1:0] entry_value;
  } sfs_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [TX_W-1:0]    texel_x;
    logic [TY_W-1:0]    texel_y;
    logic               played;
  } sfs_out_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [COLS_W-1:0] divisor;
  } sfs_div_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quotient;
    logic [COLS_W-1:0] remainder;
  } sfs_div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/sprite_frame_sequencer_top.sv
// Sprite frame sequencer: one result word per input word. A tick is compared
// with the frame interval and may cause frame advances, each one a
// compare-subtract plus one interval table read; restart, table write and
// no-op words skip that check. Every word then passes the bit-serial divider
// that splits the sheet cell index into column and row (a start state, 11
// quotient bits and a done strobe), a multiply register and the output
// register, loaded once any earlier result has been taken. The next word
// can be taken in the cycle out_valid rises. in_ready is high only between
// words; a finished result waits in the output register while the next word is taken.
`default_nettype none

module sprite_frame_sequencer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire sfs_pkg::sfs_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output sfs_pkg::sfs_out_t                     out_data
);
  import sfs_pkg::*;

  // configuration
  logic [COUNT_W-1:0]  frame_count;
  logic [LIMIT_W-1:0]  loop_limit;
  logic [POS_W-1:0]    start_position;
  logic [COLS_W-1:0]   sheet_columns;
  logic [CELL_W-1:0]   cell_width;
  logic [CELL_W-1:0]   cell_height;

  // sequence state
  logic [FRAME_W-1:0]  frame_index;
  logic [TICK_W-1:0]   tick_count;
  logic [LOOP_W-1:0]   loops_done;
  logic [IVAL_W-1:0]   current_interval;

  // interval table
  logic [IVAL_W-1:0]   interval_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] entry_valid;
  logic [IVAL_W-1:0]   rd_data;
  logic                rd_valid;

  sfs_state_t          state, state_next;
  logic                accept;
  logic                load_out;

  logic [COUNT_W-1:0]  eff_len;
  logic                endless;
  logic                reached;
  logic [IVAL_W-1:0]   eff_int;
  logic                tick_over;
  logic [COUNT_W-1:0]  frame_inc;
  logic [FRAME_W-1:0]  frame_next;
  logic                loop_inc;
  logic [COLS_W-1:0]   cols;
  logic                played;

  sfs_div_req_t        div_req;
  sfs_div_rsp_t        div_rsp;

  logic [TX_W-1:0]     prod_x;
  logic [TY_W-1:0]     prod_y;
  logic [COLS_W+CELL_W-1:0] mul_x;
  logic [SUM_W+CELL_W-1:0]  mul_y;

  assign accept = in_valid && in_ready;

  assign eff_len = (frame_count == '0) ? COUNT_W'(1) :
                   (frame_count > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : frame_count;
  assign endless = loop_limit[LIMIT_W-1];
  assign reached = !endless && (loops_done >= loop_limit[LOOP_W-1:0]);
  assign eff_int = (current_interval == '0) ? IVAL_W'(1) : current_interval;
  assign tick_over = tick_count > {1'b0, eff_int};
  assign cols = (sheet_columns == '0) ? COLS_W'(1) : sheet_columns;

  // next frame on an advance: wrap and count a loop (not when endless), or hold at the end
  always_comb begin
    frame_inc  = {1'b0, frame_index} + 1'b1;
    loop_inc   = 1'b0;
    frame_next = frame_inc[FRAME_W-1:0];
    if (frame_inc >= eff_len) begin
      if (reached) begin
        frame_next = FRAME_W'(eff_len - 1'b1);
      end else begin
        frame_next = '0;
        loop_inc   = !endless;
      end
    end
  end

  assign played = reached && ({1'b0, frame_index} == eff_len - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    load_out        = 1'b0;
    div_req.start   = 1'b0;
    div_req.dividend = SUM_W'(start_position) + SUM_W'(frame_index);
    div_req.divisor = cols;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_data.operation == OP_TICK) ? ST_CHECK : ST_DIV_START;
        end
      end
      ST_CHECK: begin
        state_next = tick_over ? ST_LOAD : ST_DIV_START;
      end
      ST_LOAD: begin
        state_next = ST_CHECK;
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  sfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // config writes and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count      <= COUNT_W'(1);
      loop_limit       <= '1;
      start_position   <= '0;
      sheet_columns    <= COLS_W'(1);
      cell_width       <= CELL_W'(1);
      cell_height      <= CELL_W'(1);
      frame_index      <= '0;
      tick_count       <= '0;
      loops_done       <= '0;
      current_interval <= IVAL_W'(1);
      entry_valid      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_COUNT:   frame_count    <= cfg_data[COUNT_W-1:0];
          REG_LOOP_LIMIT:    loop_limit     <= cfg_data[LIMIT_W-1:0];
          REG_START_POS:     start_position <= cfg_data[POS_W-1:0];
          REG_SHEET_COLUMNS: sheet_columns  <= cfg_data[COLS_W-1:0];
          REG_CELL_WIDTH:    cell_width     <= cfg_data[CELL_W-1:0];
          REG_CELL_HEIGHT:   cell_height    <= cfg_data[CELL_W-1:0];
          REG_BASE_INTERVAL: begin
            current_interval <= cfg_data[IVAL_W-1:0];
          end
          default: ;
        endcase
      end

      if (accept) begin
        unique case (in_data.operation)
          OP_TICK:    tick_count <= tick_count + 1'b1;
          OP_RESTART: begin
            frame_index <= '0;
            tick_count  <= '0;
            loops_done  <= '0;
          end
          OP_WRITE:   entry_valid[in_data.entry_index] <= 1'b1;
          OP_NOP:     ;
          default:    ;
        endcase
      end

      if (state == ST_CHECK && tick_over) begin
        tick_count  <= tick_count - {1'b0, eff_int};
        frame_index <= frame_next;
        if (loop_inc) begin
          loops_done <= loops_done + 1'b1;
        end
      end

      // a written, nonzero table entry of the frame just entered overrides the interval
      if (state == ST_LOAD && rd_valid && rd_data != '0) begin
        current_interval <= rd_data;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // table memory, read address is the frame being entered
  always_ff @(posedge clk) begin
    if (accept && in_data.operation == OP_WRITE) begin
      interval_mem[in_data.entry_index] <= in_data.entry_value;
    end
    rd_data  <= interval_mem[frame_next];
    rd_valid <= entry_valid[frame_next];
  end

  assign mul_x = div_rsp.remainder * cell_width;
  assign mul_y = div_rsp.quotient * cell_height;

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod_x <= mul_x[TX_W-1:0];
      prod_y <= mul_y[TY_W-1:0];
    end
    if (load_out) begin
      out_data.frame   <= frame_index;
      out_data.texel_x <= prod_x;
      out_data.texel_y <= prod_y;
      out_data.played  <= played;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sfs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module sfs_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sfs_pkg::sfs_div_req_t req,
  output sfs_pkg::sfs_div_rsp_t     rsp
);
  import sfs_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [COLS_W-1:0]    divisor;
  logic [COLS_W-1:0]    rem;
  logic [SUM_W-1:0]     quot;
  logic [COLS_W:0]      trial;
  logic [COLS_W:0]      diff;
  logic                 ge;

  // remainder stays below the divisor, so one extra bit holds the trial
  assign trial = {rem, quot[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(SUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quot    <= req.dividend;
    end else if (busy) begin
      rem  <= ge ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
      quot <= {quot[SUM_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

### verif/tb_sprite_frame_sequencer_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the sprite frame sequencer top level
module tb_sprite_frame_sequencer_top;
  import sfs_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sfs_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sfs_out_t              out_data;

  sprite_frame_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer registers and state as the testbench sees them
  logic [6:0]         seq_len_reg;
  logic [8:0]         loop_limit_reg;
  logic [9:0]         start_pos_reg;
  logic [6:0]         columns_reg;
  logic [9:0]         cell_w_reg;
  logic [9:0]         cell_h_reg;
  logic [FRAME_W-1:0] cur_frame;
  logic [TICK_W-1:0]  tick_cnt;
  logic [LOOP_W-1:0]  loops_done;
  logic [IVAL_W-1:0]  cur_ival;
  logic [IVAL_W-1:0]  ival_table [MAX_FRAMES];

  sfs_out_t expected_frames [$];

  logic        quiet = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned mismatches = 0;
  int unsigned frames_checked = 0;
  int unsigned settings_done = 0;
  int unsigned n_ticks = 0;
  int unsigned n_restarts = 0;
  int unsigned n_writes = 0;
  int unsigned n_nops = 0;

  function automatic int seq_len();
    if (seq_len_reg == 0) return 1;
    if (seq_len_reg > MAX_FRAMES) return MAX_FRAMES;
    return int'(seq_len_reg);
  endfunction

  // negative limit means endless, loops are not counted then
  function automatic logic limit_hit();
    return !loop_limit_reg[8] && (loops_done >= loop_limit_reg[7:0]);
  endfunction

  function automatic sfs_in_t make_word(input sfs_op_t op, input int unsigned idx,
                                        input int unsigned val);
    sfs_in_t w;
    w.operation   = op;
    w.entry_index = FRAME_W'(idx);
    w.entry_value = IVAL_W'(val);
    return w;
  endfunction

  task automatic step_sequencer(input sfs_in_t w);
    logic [TICK_W-1:0] ival;
    int                nxt;
    int                cols;
    int                cell_idx;
    sfs_out_t          r;
    case (sfs_op_t'(w.operation))
      OP_TICK: begin
        n_ticks++;
        tick_cnt = tick_cnt + 1'b1;
        ival = (cur_ival == 0) ? TICK_W'(1) : TICK_W'(cur_ival);
        while (tick_cnt > ival) begin
          tick_cnt = tick_cnt - ival;
          nxt = int'(cur_frame) + 1;
          if (nxt >= seq_len()) begin
            if (limit_hit()) begin
              nxt = seq_len() - 1;
            end else begin
              nxt = 0;
              if (!loop_limit_reg[8]) loops_done = loops_done + 1'b1;
            end
          end
          cur_frame = FRAME_W'(nxt);
          // a table override takes effect on entering the frame
          if (ival_table[cur_frame] != 0) cur_ival = ival_table[cur_frame];
          ival = (cur_ival == 0) ? TICK_W'(1) : TICK_W'(cur_ival);
        end
      end
      OP_RESTART: begin
        n_restarts++;
        cur_frame  = '0;
        tick_cnt   = '0;
        loops_done = '0;
      end
      OP_WRITE: begin
        n_writes++;
        ival_table[w.entry_index] = w.entry_value;
      end
      default: begin
        n_nops++;
      end
    endcase
    cols = (columns_reg == 0) ? 1 : int'(columns_reg);
    cell_idx = int'(start_pos_reg) + int'(cur_frame);
    r.frame   = cur_frame;
    r.texel_x = TX_W'((cell_idx % cols) * int'(cell_w_reg));
    r.texel_y = TY_W'((cell_idx / cols) * int'(cell_h_reg));
    r.played  = limit_hit() && (int'(cur_frame) == seq_len() - 1);
    expected_frames.push_back(r);
  endtask

  task automatic check_frame(input sfs_out_t got);
    sfs_out_t want;
    if (expected_frames.size() == 0) begin
      $error("result word with no expectation waiting");
      mismatches++;
    end else begin
      want = expected_frames.pop_front();
      frames_checked++;
      if (got.frame !== want.frame) begin
        $error("frame expected %0d got %0d", want.frame, got.frame);
        mismatches++;
      end
      if (got.texel_x !== want.texel_x) begin
        $error("texel_x expected %0d got %0d", want.texel_x, got.texel_x);
        mismatches++;
      end
      if (got.texel_y !== want.texel_y) begin
        $error("texel_y expected %0d got %0d", want.texel_y, got.texel_y);
        mismatches++;
      end
      if (got.played !== want.played) begin
        $error("played expected %0d got %0d", want.played, got.played);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_frame(out_data);
      rx_hold = quiet ? 0 : $urandom_range(0, 4);
    end
  end

  // receiver stalls before taking the next result word
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input sfs_in_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_sequencer(w);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] frames, limit, start, columns,
                                input logic [15:0] cw, ch, ival);
    logic [15:0] vals [7];
    sfs_reg_t    sel;
    vals = '{frames, limit, start, columns, cw, ch, ival};
    wait_idle();
    sel = REG_FRAME_COUNT;
    do begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= sel;
      cfg_data  <= vals[sel];
      sel = sel.next();
    end while (sel != REG_FRAME_COUNT);
    @(negedge clk);
    cfg_write <= 1'b0;
    seq_len_reg    = frames[6:0];
    loop_limit_reg = limit[8:0];
    start_pos_reg  = start[9:0];
    columns_reg    = columns[6:0];
    cell_w_reg     = cw[9:0];
    cell_h_reg     = ch[9:0];
    cur_ival       = ival;
    settings_done++;
  endtask

  task automatic test_reset_defaults();
    send_word(make_word(OP_NOP, 0, 0));
    send_word(make_word(OP_TICK, 63, 16'hFFFF));
    send_word(make_word(OP_TICK, 0, 0));
    send_word(make_word(OP_RESTART, 42, 16'h5A5A));
  endtask

  task automatic test_field_extremes();
    // zero columns, zero interval, frame count above the maximum
    apply_settings(16'd127, 16'd0, 16'd1023, 16'd0, 16'd1023, 16'd1023, 16'd0);
    send_word(make_word(OP_WRITE, 63, 16'hFFFF));
    send_word(make_word(OP_WRITE, 0, 0));
    send_word(make_word(OP_TICK, 0, 0));
    send_word(make_word(OP_TICK, 0, 0));
    send_word(make_word(OP_TICK, 0, 0));
    send_word(make_word(OP_NOP, 63, 16'hFFFF));
    send_word(make_word(OP_RESTART, 0, 0));
    // zero frame count, widest interval
    apply_settings(16'd0, 16'd255, 16'd0, 16'd64, 16'd1, 16'd1, 16'hFFFF);
    send_word(make_word(OP_TICK, 0, 0));
    send_word(make_word(OP_WRITE, 0, 1));
    send_word(make_word(OP_RESTART, 0, 0));
    send_word(make_word(OP_TICK, 0, 0));
    send_word(make_word(OP_TICK, 0, 0));
  endtask

  task automatic test_limit_changes();
    apply_settings(16'd6, 16'd3, 16'd5, 16'd4, 16'd7, 16'd9, 16'd1);
    repeat (4) send_word(make_word(OP_TICK, 0, 0));
    // frame now sits beyond the shorter sequence
    apply_settings(16'd2, 16'd3, 16'd5, 16'd4, 16'd7, 16'd9, 16'd1);
    send_word(make_word(OP_TICK, 0, 0));
    // limit dropped below the loops already done
    apply_settings(16'd2, 16'd0, 16'd5, 16'd4, 16'd7, 16'd9, 16'd1);
    repeat (3) send_word(make_word(OP_TICK, 0, 0));
    apply_settings(16'd2, 16'h01FF, 16'd5, 16'd4, 16'd7, 16'd9, 16'd1);
    repeat (2) send_word(make_word(OP_TICK, 0, 0));
  endtask

  task automatic test_random_phases(input int unsigned total);
    int unsigned sent;
    int unsigned span;
    int unsigned pick;
    logic [15:0] fc, ll, sp, sc, cw, ch, bi;
    sfs_in_t     w;
    sent = 0;
    while (sent < total) begin
      pick = $urandom_range(0, 7);
      fc = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(64, 127)) :
           (pick == 2) ? 16'($urandom_range(1, 64)) : 16'($urandom_range(1, 12));
      pick = $urandom_range(0, 7);
      ll = (pick == 0) ? 16'h01FF : (pick == 1) ? 16'(9'h100 | $urandom_range(0, 255)) :
           (pick == 2) ? 16'd255 : (pick == 3) ? 16'($urandom_range(0, 255)) :
           16'($urandom_range(0, 4));
      sp = 16'($urandom_range(0, 1023));
      pick = $urandom_range(0, 7);
      sc = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(0, 127)) :
           16'($urandom_range(1, 64));
      cw = ($urandom_range(0, 7) == 0) ? 16'd1023 : 16'($urandom_range(0, 1023));
      ch = ($urandom_range(0, 7) == 0) ? 16'd1023 : 16'($urandom_range(0, 1023));
      pick = $urandom_range(0, 15);
      bi = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
           (pick < 5) ? 16'($urandom_range(20, 300)) : 16'($urandom_range(1, 6));
      apply_settings(fc, ll, sp, sc, cw, ch, bi);
      quiet = ($urandom_range(0, 3) == 0);
      span = $urandom_range(40, 110);
      repeat (span) begin
        w.entry_index = FRAME_W'($urandom_range(0, MAX_FRAMES - 1));
        w.entry_value = IVAL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          w.operation = OP_TICK;
        end else if (pick < 70) begin
          w.operation = OP_RESTART;
        end else if (pick < 92) begin
          w.operation = OP_WRITE;
          // mostly short overrides so frames keep moving
          pick = $urandom_range(0, 7);
          if (pick == 0) w.entry_value = '0;
          else if (pick > 1) w.entry_value = IVAL_W'($urandom_range(1, 6));
        end else begin
          w.operation = OP_NOP;
        end
        send_word(w);
      end
      sent += span;
    end
    quiet = 1'b0;
  endtask

  initial begin
    seq_len_reg    = 7'd1;
    loop_limit_reg = 9'h1FF;
    start_pos_reg  = '0;
    columns_reg    = 7'd1;
    cell_w_reg     = 10'd1;
    cell_h_reg     = 10'd1;
    cur_frame      = '0;
    tick_cnt       = '0;
    loops_done     = '0;
    cur_ival       = 16'd1;
    foreach (ival_table[i]) ival_table[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_limit_changes();
    test_random_phases(1824);

    wait_idle();
    repeat (30) @(posedge clk);
    $display("covered %0d ticks, %0d restarts, %0d table writes, %0d no-ops",
             n_ticks, n_restarts, n_writes, n_nops);
    $display("across %0d register settings; %0d result words checked, %0d mismatches",
             settings_done, frames_checked, mismatches);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d result words outstanding", expected_frames.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
